// ===== design/s2t_pkg.sv =====
// Shared types and constants for the stride-2 trie longest-prefix-match engine.
package s2t_pkg;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;
  localparam int unsigned MAX_DEPTH = 16;

  // One queued item between the front and back parts.
  typedef struct packed {
    logic        op;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [15:0] port_in;
  } item_t;

  // Route entry: valid, length and port.
  typedef struct packed {
    logic        valid;
    logic [5:0]  len;
    logic [15:0] port;
  } route_t;

  // Two address bits that pick the child of a node at the given depth.
  function automatic logic [1:0] symbol_at(input logic [31:0] addr, input logic [3:0] depth);
    logic [4:0] sh;
    logic [31:0] tmp;
    sh = 5'd30 - {depth, 1'b0};
    tmp = addr >> sh;
    return tmp[1:0];
  endfunction

endpackage

// ===== design/s2t_front.sv =====
// Front part: accepts items, clamps the prefix length and queues them.
module s2t_front import s2t_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        op,
  input  logic [31:0] address,
  input  logic [5:0]  prefix_len,
  input  logic [15:0] port_in,
  output logic        busy,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int QDEPTH = 2;

  item_t      mem [QDEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  item_t      in_item;

  always_comb begin
    in_item.op = op;
    in_item.address = address;
    in_item.prefix_len = (prefix_len > 6'd32) ? 6'd32 : prefix_len;
    in_item.port_in = port_in;
  end

  assign busy = (count == 2'(QDEPTH));
  assign push = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== design/s2t_back.sv =====
// Back part: walks the trie in node memories for lookups and inserts.
module s2t_back import s2t_pkg::*; #(
  parameter int NODE_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        done,
  output logic        hit,
  output logic [15:0] port_out,
  output logic        status
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int LW = NW + 2;
  localparam int CW = NW + 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_LK    = 4'd3;
  localparam logic [3:0] S_INS   = 4'd4;
  localparam logic [3:0] S_RRD   = 4'd5;
  localparam logic [3:0] S_RWR   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [NW-1:0] link_mem [NODE_COUNT*4];
  route_t        route_mem [NODE_COUNT];
  logic [NW-1:0] link_rd;
  route_t        route_rd;

  logic [3:0]    state;
  logic [LW-1:0] clr_idx;
  logic [CW-1:0] next_free;
  item_t         cur;
  logic [NW-1:0] node;
  logic [4:0]    depth;
  logic [4:0]    target;
  logic          second;   // second sibling of an odd-length route
  logic [NW-1:0] dest;
  logic          r_hit;
  logic [15:0]   r_port;
  logic          r_fail;

  logic [1:0]    sym;
  logic [1:0]    ins_sym;
  logic          last_lvl;
  logic          pool_full;

  assign last_lvl = (depth + 5'd1 == target);
  assign sym = symbol_at(cur.address, depth[3:0]);
  assign ins_sym = (cur.op == OP_LOOKUP || !last_lvl) ? sym :
                   (cur.prefix_len[0] ? {sym[1], second} : sym);
  assign pool_full = (next_free >= CW'(NODE_COUNT));

  always_ff @(posedge clk) begin
    link_rd  <= link_mem[{node, ins_sym}];
    route_rd <= route_mem[dest];
    if (state == S_CLEAR) begin
      link_mem[clr_idx] <= '0;
      route_mem[clr_idx[LW-1:2]] <= '0;
    end else if (state == S_INS && link_rd == '0 && !pool_full) begin
      link_mem[{node, ins_sym}] <= next_free[NW-1:0];
    end else if (state == S_RWR && (!route_rd.valid || cur.prefix_len >= route_rd.len)) begin
      route_mem[dest] <= '{valid: 1'b1, len: cur.prefix_len, port: cur.port_in};
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;
  assign done = (state == S_DONE);
  assign hit = r_hit;
  assign port_out = r_port;
  assign status = r_fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      next_free <= CW'(1);
      node <= '0;
      dest <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + LW'(1);
          if (clr_idx == LW'(NODE_COUNT*4-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            node <= '0;
            dest <= '0;
            depth <= '0;
            second <= 1'b0;
            target <= 5'((q_item.prefix_len + 6'd1) >> 1);
            r_hit <= 1'b0;
            r_port <= '0;
            r_fail <= 1'b0;
            if (q_item.op == OP_INSERT && q_item.prefix_len == 6'd0) state <= S_RRD;
            else state <= S_RD;
          end
        end
        S_RD: begin
          // For lookups dest == node here; route and link reads issue together.
          state <= (cur.op == OP_LOOKUP) ? S_LK : S_INS;
        end
        S_LK: begin
          if (route_rd.valid) begin
            r_hit <= 1'b1;
            r_port <= route_rd.port;
          end
          if (depth == 5'(MAX_DEPTH) || link_rd == '0) begin
            state <= S_DONE;
          end else begin
            node <= link_rd;
            dest <= link_rd;
            depth <= depth + 5'd1;
            state <= S_RD;
          end
        end
        S_INS: begin
          if (link_rd == '0 && pool_full) begin
            r_fail <= 1'b1;
            state <= S_DONE;
          end else begin
            if (link_rd == '0) next_free <= next_free + CW'(1);
            if (!last_lvl) begin
              node <= (link_rd == '0) ? next_free[NW-1:0] : link_rd;
              depth <= depth + 5'd1;
              state <= S_RD;
            end else if (cur.prefix_len[0] && !second) begin
              // Allocate both siblings before writing routes.
              dest <= (link_rd == '0) ? next_free[NW-1:0] : link_rd;
              second <= 1'b1;
              state <= S_RD;
            end else begin
              // The first sibling is parked in node while the second is written.
              if (second) node <= dest;
              dest <= (link_rd == '0) ? next_free[NW-1:0] : link_rd;
              state <= S_RRD;
            end
          end
        end
        S_RRD: state <= S_RWR;
        S_RWR: begin
          if (cur.prefix_len[0] && second) begin
            // Swap in the first sibling that was parked in node.
            second <= 1'b0;
            node <= dest;
            state <= S_RRD;
            dest <= node;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/stride2_trie_longest_prefix_match.sv =====
// Top level of the stride-2 trie longest-prefix-match engine.
// An item is taken when start is high and busy is low: op 0 looks up
// address, op 1 inserts the route address/prefix_len with port port_in.
// Each item gives one result, shown for one cycle while done is high:
// hit and port_out for lookups, status 1 for an insert that ran out of nodes.
// A two-entry queue sits between the input side and the trie walker, so
// busy is low while that queue has room.
// A lookup pops the queue, visits at most 17 levels with a read and a
// decision step each, and shows its result; an insert walks its levels
// likewise, then reads and writes the route before the result, and for an
// odd length also does the second sibling's link and route.
// After reset the walker clears both memories, one link entry a cycle;
// items are queued but not served until it ends.
// The receiver cannot stall; done lasts one cycle per result.
module stride2_trie_longest_prefix_match import s2t_pkg::*; #(
  parameter int NODE_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] address,
  input  logic [5:0]  prefix_len,
  input  logic [15:0] port_in,
  output logic        done,
  output logic        hit,
  output logic [15:0] port_out,
  output logic        status
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  s2t_front u_front (
    .clk(clk), .rst(rst), .start(start), .op(op), .address(address),
    .prefix_len(prefix_len), .port_in(port_in), .busy(busy),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  s2t_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .done(done), .hit(hit), .port_out(port_out), .status(status)
  );

endmodule
